// ----- rtl/core/sspq_pkg.sv -----
// shared types and codes for the stable sorted priority queue
package sspq_pkg;

  localparam logic [1:0] OP_ENQ = 2'd0;
  localparam logic [1:0] OP_DEQ = 2'd1;
  localparam logic [1:0] OP_PEEK = 2'd2;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic [31:0] head_elem;
    logic [31:0] head_prio;
    logic [4:0]  entry_count;
    logic        is_empty;
    logic [1:0]  status;
  } rslt_t;

endpackage

// ----- rtl/core/stable_sorted_priority_queue.sv -----
// top level of the stable sorted priority queue with stream ports
// usage:
//   s_* carries one request: s_tuser holds the operation (enqueue, dequeue,
//   peek), s_tdata the element word and its priority. every request yields
//   exactly one result on m_*: head element and priority after the request,
//   entry count, empty flag in m_tdata, and a status code in m_tuser
//   (ok, enqueue rejected when full, dequeue on empty). entries sit in a ring
//   in one synchronous memory; the smallest priority is at the head, equal
//   priorities leave in arrival order.
// sequence (accept edge to m_tvalid high):
//   peek, rejected requests, enqueue into an empty queue: no memory read
//   dequeue: one memory read fetches the new head, unless the queue empties
//   enqueue that moves k entries toward the tail: one entry per cycle through
//   the memory's read port and write port, then the new entry is written
//   one request at a time; s_tready is high again the cycle after the result
//   moves into the output register, so no new request is taken before then
// reset: rst is synchronous, active high; the queue comes up empty and the
//   store contents are not cleared
// stall: while m_tready is low the result waits in the output register; the
//   next request is accepted and worked on and holds its result until then
module stable_sorted_priority_queue
  import sspq_pkg::*;
#(
  parameter int CAPACITY = 16,
  parameter int ELEM_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,  // elem_in [31:0], prio_in [63:32]
  input  logic [1:0]  s_tuser,  // func [1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [71:0] m_tdata,  // head_elem [31:0], head_prio [63:32],
                                // entry_count [68:64], is_empty [69], zero pad
  output logic [1:0]  m_tuser   // status [1:0]
);

  logic [63:0]           elem_wide;
  logic [ELEM_WIDTH-1:0] elem;
  logic                  res_valid;
  logic                  res_ready;
  rslt_t                 res;
  rslt_t                 out_reg;

  // only the low ELEM_WIDTH bits of the element word are kept
  assign elem_wide = {32'd0, s_tdata[31:0]};
  assign elem = elem_wide[ELEM_WIDTH-1:0];

  sspq_ctrl #(
    .CAPACITY(CAPACITY),
    .ELEM_WIDTH(ELEM_WIDTH)
  ) u_ctrl (
    .clk(clk),
    .rst(rst),
    .in_valid(s_tvalid),
    .in_ready(s_tready),
    .op(s_tuser),
    .elem(elem),
    .prio(s_tdata[63:32]),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .res(res)
  );

  // output register decouples the sequencer from a stalled receiver
  assign res_ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_ready) begin
      m_tvalid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_reg <= res;
    end
  end

  assign m_tdata = {2'b00, out_reg.is_empty, out_reg.entry_count,
                    out_reg.head_prio, out_reg.head_elem};
  assign m_tuser = out_reg.status;

endmodule

// ----- rtl/core/sspq_mem.sv -----
// entry store: one write port, one registered read port
module sspq_mem #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 64,
  parameter int AW = 4
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] ram [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      ram[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= ram[raddr];
    end
  end

endmodule

// ----- rtl/core/sspq_ctrl.sv -----
// sequencer: ring pointers, head copy, insertion scan and shift
module sspq_ctrl
  import sspq_pkg::*;
#(
  parameter int CAPACITY = 16,
  parameter int ELEM_WIDTH = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [1:0]            op,
  input  logic [ELEM_WIDTH-1:0] elem,
  input  logic [31:0]           prio,
  output logic                  res_valid,
  input  logic                  res_ready,
  output rslt_t                 res
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int SW = AW + 1;
  localparam int MW = ELEM_WIDTH + 32;
  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);
  localparam logic [SW-1:0] CAP_S = SW'(CAPACITY);
  localparam logic [AW-1:0] LAST_A = AW'(CAPACITY - 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_PUT = 3'd2;
  localparam logic [2:0] S_HEAD = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  logic [2:0]            state, state_next;
  logic [AW-1:0]         base, base_next;
  logic [CW-1:0]         count, count_next;
  logic [AW-1:0]         cur, cur_next;
  logic [CW-1:0]         left, left_next;
  logic [ELEM_WIDTH-1:0] head_elem, head_elem_next;
  logic [31:0]           head_prio, head_prio_next;
  logic [ELEM_WIDTH-1:0] new_elem, new_elem_next;
  logic [31:0]           new_prio, new_prio_next;
  logic [1:0]            status, status_next;

  logic                  mem_we, mem_re;
  logic [AW-1:0]         mem_waddr, mem_raddr;
  logic [MW-1:0]         mem_wdata, mem_rdata;
  logic [ELEM_WIDTH-1:0] rd_elem;
  logic [31:0]           rd_prio;
  logic [SW-1:0]         tail_sum;
  logic [AW-1:0]         tail;
  logic [63:0]           head_wide;
  logic [31:0]           count_wide;

  function automatic logic [AW-1:0] ring_inc(input logic [AW-1:0] x);
    ring_inc = (x == LAST_A) ? '0 : x + AW'(1);
  endfunction

  function automatic logic [AW-1:0] ring_dec(input logic [AW-1:0] x);
    ring_dec = (x == '0) ? LAST_A : x - AW'(1);
  endfunction

  sspq_mem #(
    .DEPTH(CAPACITY),
    .WIDTH(MW),
    .AW(AW)
  ) u_mem (
    .clk(clk),
    .we(mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .re(mem_re),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  assign rd_elem = mem_rdata[ELEM_WIDTH-1:0];
  assign rd_prio = mem_rdata[MW-1:ELEM_WIDTH];

  // free slot just past the last entry
  assign tail_sum = SW'(base) + SW'(count);
  assign tail = (tail_sum >= CAP_S) ? AW'(tail_sum - CAP_S) : AW'(tail_sum);

  assign in_ready = (state == S_IDLE);
  assign res_valid = (state == S_DONE);

  always_comb begin
    state_next = state;
    base_next = base;
    count_next = count;
    cur_next = cur;
    left_next = left;
    head_elem_next = head_elem;
    head_prio_next = head_prio;
    new_elem_next = new_elem;
    new_prio_next = new_prio;
    status_next = status;
    mem_we = 1'b0;
    mem_waddr = '0;
    mem_wdata = '0;
    mem_re = 1'b0;
    mem_raddr = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          status_next = ST_OK;
          state_next = S_DONE;
          if (op == OP_ENQ) begin
            new_elem_next = elem;
            new_prio_next = prio;
            if (count == CAP_C) begin
              status_next = ST_FULL;
            end else if (count == '0) begin
              mem_we = 1'b1;
              mem_waddr = base;
              mem_wdata = {prio, elem};
              head_elem_next = elem;
              head_prio_next = prio;
              count_next = CW'(1);
            end else begin
              cur_next = tail;
              left_next = count;
              mem_re = 1'b1;
              mem_raddr = ring_dec(tail);
              state_next = S_SCAN;
            end
          end else if (op == OP_DEQ) begin
            if (count == '0) begin
              status_next = ST_EMPTY;
            end else begin
              base_next = ring_inc(base);
              count_next = count - CW'(1);
              if (count != CW'(1)) begin
                mem_re = 1'b1;
                mem_raddr = ring_inc(base);
                state_next = S_HEAD;
              end
            end
          end
        end
      end
      S_SCAN: begin
        mem_we = 1'b1;
        mem_waddr = cur;
        if (rd_prio > new_prio) begin
          // larger priority moves one slot toward the tail
          mem_wdata = mem_rdata;
          cur_next = ring_dec(cur);
          left_next = left - CW'(1);
          if (left == CW'(1)) begin
            state_next = S_PUT;
          end else begin
            mem_re = 1'b1;
            mem_raddr = ring_dec(ring_dec(cur));
          end
        end else begin
          // stop after equals so arrival order is kept
          mem_wdata = {new_prio, new_elem};
          count_next = count + CW'(1);
          state_next = S_DONE;
        end
      end
      S_PUT: begin
        mem_we = 1'b1;
        mem_waddr = cur;
        mem_wdata = {new_prio, new_elem};
        head_elem_next = new_elem;
        head_prio_next = new_prio;
        count_next = count + CW'(1);
        state_next = S_DONE;
      end
      S_HEAD: begin
        head_elem_next = rd_elem;
        head_prio_next = rd_prio;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (res_ready) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      base <= '0;
      count <= '0;
      cur <= '0;
      left <= '0;
    end else begin
      state <= state_next;
      base <= base_next;
      count <= count_next;
      cur <= cur_next;
      left <= left_next;
    end
  end

  always_ff @(posedge clk) begin
    head_elem <= head_elem_next;
    head_prio <= head_prio_next;
    new_elem <= new_elem_next;
    new_prio <= new_prio_next;
    status <= status_next;
  end

  assign head_wide = 64'(head_elem);
  assign count_wide = 32'(count);

  always_comb begin
    res.head_elem = (count == '0) ? 32'd0 : head_wide[31:0];
    res.head_prio = (count == '0) ? 32'd0 : head_prio;
    res.entry_count = count_wide[4:0];
    res.is_empty = (count == '0);
    res.status = status;
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CAP_C) else $error("entry count above capacity");
  a_scan_left: assert property (@(posedge clk) disable iff (rst)
    state == S_SCAN |-> left != '0) else $error("scan with no entries left");
  a_port_clash: assert property (@(posedge clk) disable iff (rst)
    mem_we && mem_re |-> mem_waddr != mem_raddr)
    else $error("read and write of the same entry");
  a_leave_idle: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE && in_valid |=> state != S_IDLE)
    else $error("accepted request not started");
`endif

endmodule
